// ===== rtl/pngse_pkg.sv =====
// shared types, constants and byte helpers for the png stored-stream encoder
package pngse_pkg;

   localparam int DIM_W      = 15;
   localparam int MAX_DIM    = 16384;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
   localparam int CSR_ADDR_W = 3;

   localparam logic [5:0]  HDR_LAST   = 6'd42;
   localparam logic [4:0]  TRL_LAST   = 5'd19;
   localparam logic [15:0] BLOCK_MAX  = 16'hFFFF;
   localparam logic [16:0] ADLER_MOD  = 17'd65521;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

   // register select is address bit 2
   localparam logic CSR_SEL_WIDTH  = 1'b0;
   localparam logic CSR_SEL_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             start;
      logic             row_start;
      logic             finish;
      logic             trailer;
   } pngse_cmd_type;

   typedef enum logic [1:0] {
      PH_HDR,
      PH_RAW,
      PH_TRL
   } pngse_phase_type;

   function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
      end
      return x;
   endfunction

   // big-endian byte s of a word
   function automatic logic [7:0] be_byte(logic [31:0] x, logic [1:0] s);
      logic [7:0] b;
      case (s)
         2'd0:    b = x[31:24];
         2'd1:    b = x[23:16];
         2'd2:    b = x[15:8];
         default: b = x[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] sig_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = 8'h89;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h4E;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0D;
         3'd5:    b = 8'h0A;
         3'd6:    b = 8'h1A;
         default: b = 8'h0A;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/pngse_front.sv =====
// front end: tracks raster position and turns each pixel into a queued command
module pngse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pix_valid,
   input  logic [31:0]                 pix_data,
   input  logic                        q_full,
   input  logic [pngse_pkg::DIM_W-1:0] cfg_width,
   input  logic [pngse_pkg::DIM_W-1:0] cfg_height,
   output logic                        q_push,
   output pngse_pkg::pngse_cmd_type    q_cmd
);
   import pngse_pkg::*;

   logic             started_ff, started_in;
   logic             pending_ff, pending_in;
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] run_w_ff, run_w_in, run_h_ff, run_h_in;
   logic             st, row_end, img_end;
   logic [DIM_W-1:0] w_use, h_use, col_cur, row_cur, col_inc, row_inc;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = v;
      return r;
   endfunction

   always_comb begin
      st      = !started_ff;
      w_use   = st ? clamp_dim(cfg_width) : run_w_ff;
      h_use   = st ? clamp_dim(cfg_height) : run_h_ff;
      col_cur = st ? '0 : col_ff;
      row_cur = st ? '0 : row_ff;
      col_inc = col_cur + DIM_W'(1);
      row_inc = row_cur + DIM_W'(1);
      row_end = col_inc >= w_use;
      img_end = row_end && (row_inc >= h_use);

      q_push          = pix_valid && !q_full;
      q_cmd.red       = pix_data[7:0];
      q_cmd.green     = pix_data[15:8];
      q_cmd.blue      = pix_data[23:16];
      q_cmd.alpha     = pix_data[31:24];
      q_cmd.width     = w_use;
      q_cmd.height    = h_use;
      q_cmd.trailer   = pending_ff;
      q_cmd.start     = st && !pending_ff;
      q_cmd.row_start = col_cur == '0;
      q_cmd.finish    = img_end && !st && !pending_ff;

      started_in = started_ff;
      pending_in = pending_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      run_w_in   = run_w_ff;
      run_h_in   = run_h_ff;
      if (q_push) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            started_in = 1'b0;
         end else begin
            // a one-pixel image defers its closing bytes to the next beat
            started_in = !img_end || st;
            pending_in = img_end && st;
            run_w_in   = w_use;
            run_h_in   = h_use;
            col_in     = row_end ? '0 : col_inc;
            row_in     = row_end ? (img_end ? '0 : row_inc) : row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pending_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         run_w_ff   <= DIM_W'(1);
         run_h_ff   <= DIM_W'(1);
      end else begin
         started_ff <= started_in;
         pending_ff <= pending_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         run_w_ff   <= run_w_in;
         run_h_ff   <= run_h_in;
      end
   end

endmodule

// ===== rtl/pngse_queue.sv =====
// short command queue between front and back
module pngse_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pngse_pkg::pngse_cmd_type push_cmd,
   input  logic                     pop,
   output pngse_pkg::pngse_cmd_type head_cmd,
   output logic                     full,
   output logic                     empty
);
   import pngse_pkg::*;

   pngse_cmd_type      slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, rd_ff;
   logic [Q_CNT_W-1:0] cnt_ff;

   assign full     = cnt_ff == Q_CNT_W'(Q_DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_cmd = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + Q_PTR_W'(1);
         if (pop)  rd_ff <= rd_ff + Q_PTR_W'(1);
         cnt_ff <= cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
      end
   end

endmodule

// ===== rtl/pngse_back.sv =====
// back end: byte sequencer with crc-32, adler-32 and stored-block framing
module pngse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pngse_pkg::pngse_cmd_type head_cmd,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [7:0]               out_byte,
   output logic                     out_run_end,
   output logic                     out_file_end
);
   import pngse_pkg::*;

   pngse_phase_type phase_ff, phase_in, cur_phase;
   logic        busy_ff, busy_in;
   logic [5:0]  idx_ff, idx_in, cur_idx;
   logic [2:0]  sel_ff, sel_in, cur_sel;
   logic [2:0]  bh_ff, bh_in;
   logic [15:0] fill_ff, fill_in;
   logic [30:0] rem_ff, rem_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] alo_ff, alo_in, ahi_ff, ahi_in;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        last_ff, fend_ff;

   // idat length pipeline, settles long before the length is sent
   logic [30:0] raw_ff;
   logic [31:0] x_ff;
   logic [16:0] qe_ff, blocks_ff;
   logic [31:0] idat_ff;
   logic [31:0] prod;
   logic [31:0] x_calc;
   logic [32:0] qsum, qmul, qrem;

   logic        adv, crc_en, crc_init, done, fend;
   logic [7:0]  b;
   logic [15:0] n;
   logic [16:0] fill_inc, lo_sum, hi_sum;
   logic [30:0] rem_dec;
   logic [5:0]  off;

   always_comb begin
      prod   = {15'd0, head_cmd.width, 2'b01} * {17'd0, head_cmd.height};
      x_calc = {1'b0, raw_ff} + 32'd65534;
      qsum   = {1'b0, x_calc} + {17'd0, x_calc[31:16]};
      qmul   = {qe_ff, 16'd0} - {16'd0, qe_ff};
      qrem   = {1'b0, x_ff} - qmul;
   end

   always_ff @(posedge clock) begin
      raw_ff    <= prod[30:0];
      x_ff      <= x_calc;
      qe_ff     <= qsum[32:16];
      blocks_ff <= qe_ff + 17'(qrem >= 33'd65535);
      idat_ff   <= {1'b0, raw_ff} + {13'd0, blocks_ff, 2'b00} + {15'd0, blocks_ff} + 32'd6;
   end

   always_comb begin
      adv = !q_empty && (!valid_ff || out_ready);
      if (busy_ff) begin
         cur_phase = phase_ff;
         cur_idx   = idx_ff;
         cur_sel   = sel_ff;
      end else begin
         cur_phase = head_cmd.trailer ? PH_TRL : (head_cmd.start ? PH_HDR : PH_RAW);
         cur_idx   = '0;
         cur_sel   = head_cmd.row_start ? 3'd0 : 3'd1;
      end

      phase_in = cur_phase;
      idx_in   = cur_idx + 6'd1;
      sel_in   = cur_sel;
      bh_in    = bh_ff;
      fill_in  = fill_ff;
      rem_in   = rem_ff;
      alo_in   = alo_ff;
      ahi_in   = ahi_ff;
      crc_en   = 1'b0;
      crc_init = 1'b0;
      done     = 1'b0;
      fend     = 1'b0;
      b        = 8'h00;
      n        = (rem_ff < 31'(BLOCK_MAX)) ? rem_ff[15:0] : BLOCK_MAX;
      fill_inc = {1'b0, fill_ff} + 17'd1;
      rem_dec  = (rem_ff != '0) ? rem_ff - 31'd1 : '0;
      lo_sum   = '0;
      hi_sum   = '0;
      off      = '0;

      case (cur_phase)
         PH_HDR: begin
            if (cur_idx < 6'd8) b = sig_byte(cur_idx[2:0]);
            else if (cur_idx == 6'd11) b = 8'd13;
            else if (cur_idx == 6'd12) b = 8'h49;
            else if (cur_idx == 6'd13) b = 8'h48;
            else if (cur_idx == 6'd14) b = 8'h44;
            else if (cur_idx == 6'd15) b = 8'h52;
            else if (cur_idx >= 6'd16 && cur_idx < 6'd20)
               b = be_byte({17'd0, head_cmd.width}, cur_idx[1:0]);
            else if (cur_idx >= 6'd20 && cur_idx < 6'd24)
               b = be_byte({17'd0, head_cmd.height}, cur_idx[1:0]);
            else if (cur_idx == 6'd24) b = 8'd8;
            else if (cur_idx == 6'd25) b = 8'd6;
            else if (cur_idx >= 6'd29 && cur_idx < 6'd33) begin
               off = cur_idx - 6'd29;
               b   = be_byte(~crc_ff, off[1:0]);
            end else if (cur_idx >= 6'd33 && cur_idx < 6'd37) begin
               off = cur_idx - 6'd33;
               b   = be_byte(idat_ff, off[1:0]);
            end
            else if (cur_idx == 6'd37) b = 8'h49;
            else if (cur_idx == 6'd38) b = 8'h44;
            else if (cur_idx == 6'd39) b = 8'h41;
            else if (cur_idx == 6'd40) b = 8'h54;
            else if (cur_idx == 6'd41) b = 8'h78;
            else if (cur_idx == 6'd42) b = 8'h01;
            crc_en   = (cur_idx >= 6'd12 && cur_idx <= 6'd28) || cur_idx >= 6'd37;
            crc_init = cur_idx == 6'd12 || cur_idx == 6'd37;
            if (cur_idx == HDR_LAST) begin
               // zlib stream opens: block and checksum state restart
               phase_in = PH_RAW;
               sel_in   = 3'd0;
               rem_in   = raw_ff;
               fill_in  = '0;
               bh_in    = '0;
               alo_in   = 16'd1;
               ahi_in   = 16'd0;
            end
         end
         PH_RAW: begin
            crc_en = 1'b1;
            if (fill_ff == '0 && bh_ff < 3'd5) begin
               // stored block header
               case (bh_ff)
                  3'd0:    b = {7'd0, 31'(n) == rem_ff};
                  3'd1:    b = n[7:0];
                  3'd2:    b = n[15:8];
                  3'd3:    b = ~n[7:0];
                  default: b = ~n[15:8];
               endcase
               bh_in = bh_ff + 3'd1;
            end else begin
               case (cur_sel)
                  3'd0:    b = 8'h00;
                  3'd1:    b = head_cmd.red;
                  3'd2:    b = head_cmd.green;
                  3'd3:    b = head_cmd.blue;
                  default: b = head_cmd.alpha;
               endcase
               bh_in  = '0;
               lo_sum = {1'b0, alo_ff} + {9'd0, b};
               if (lo_sum >= ADLER_MOD) lo_sum = lo_sum - ADLER_MOD;
               hi_sum = {1'b0, ahi_ff} + lo_sum;
               if (hi_sum >= ADLER_MOD) hi_sum = hi_sum - ADLER_MOD;
               alo_in = lo_sum[15:0];
               ahi_in = hi_sum[15:0];
               rem_in = rem_dec;
               fill_in = (fill_inc >= {1'b0, BLOCK_MAX} || rem_dec == '0) ? '0 : fill_inc[15:0];
               if (cur_sel == 3'd4) begin
                  if (head_cmd.finish) begin
                     phase_in = PH_TRL;
                     idx_in   = '0;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  sel_in = cur_sel + 3'd1;
               end
            end
         end
         PH_TRL: begin
            if (cur_idx < 6'd4) b = be_byte({ahi_ff, alo_ff}, cur_idx[1:0]);
            else if (cur_idx < 6'd8) b = be_byte(~crc_ff, cur_idx[1:0]);
            else if (cur_idx == 6'd12) b = 8'h49;
            else if (cur_idx == 6'd13) b = 8'h45;
            else if (cur_idx == 6'd14) b = 8'h4E;
            else if (cur_idx == 6'd15) b = 8'h44;
            else if (cur_idx >= 6'd16) b = be_byte(~crc_ff, cur_idx[1:0]);
            crc_en   = cur_idx < 6'd4 || (cur_idx >= 6'd12 && cur_idx < 6'd16);
            crc_init = cur_idx == 6'd12;
            if (cur_idx[4:0] == TRL_LAST) begin
               done = 1'b1;
               fend = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase

      crc_in  = crc_en ? crc_byte(crc_init ? CRC_INIT : crc_ff, b) : crc_ff;
      busy_in = !done;
      q_pop   = adv && done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_HDR;
         idx_ff   <= '0;
         sel_ff   <= '0;
         bh_ff    <= '0;
         fill_ff  <= '0;
         rem_ff   <= '0;
         crc_ff   <= CRC_INIT;
         alo_ff   <= 16'd1;
         ahi_ff   <= 16'd0;
         valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            busy_ff  <= busy_in;
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            sel_ff   <= sel_in;
            bh_ff    <= bh_in;
            fill_ff  <= fill_in;
            rem_ff   <= rem_in;
            crc_ff   <= crc_in;
            alo_ff   <= alo_in;
            ahi_ff   <= ahi_in;
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byte_ff <= b;
         last_ff <= done;
         fend_ff <= fend;
      end
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_run_end  = last_ff;
   assign out_file_end = fend_ff;

endmodule

// ===== rtl/png_stored_stream_encoder_unit.sv =====
// top level of the png stored-stream encoder: register port, front, queue, back
//
//  channel | dir | beat                              | accepted when
//  req_    | in  | one rgba pixel                    | req_tvalid & req_tready
//  rsp_    | out | one file byte, tlast, tuser       | rsp_tvalid & rsp_tready
//  csr_    | in  | image_width @0, image_height @4   | psel & penable & pwrite
//
// one output byte per cycle while the sink is ready and a command is queued:
// 4 bytes a pixel, 5 at a row start, +5 per block header (one per 65535 raw bytes)
// first pixel of a file adds 43 header bytes, the last pixel 20 closing bytes;
// for a one-pixel image the closing bytes go out on the next pixel beat
// the byte-wide output register sets the rate; a 4-entry command queue lets
// the pixel side keep going while the byte side is stalled
// reset is synchronous and clears control state; dimensions reset to 1
module png_stored_stream_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, alpha
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_end
   output logic        rsp_tuser,   // file_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [pngse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pngse_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic             csr_wr;
   logic             q_push, q_pop, q_full, q_empty;
   pngse_cmd_type    push_cmd, head_cmd;

   // register port, always ready, address bit 2 picks the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_SEL_WIDTH)  width_ff  <= csr_pwdata[DIM_W-1:0];
         if (csr_paddr[2] == CSR_SEL_HEIGHT) height_ff <= csr_pwdata[DIM_W-1:0];
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_SEL_WIDTH:  csr_prdata = {17'd0, width_ff};
         CSR_SEL_HEIGHT: csr_prdata = {17'd0, height_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // front takes a pixel whenever the queue has room
   assign req_tready = !q_full;

   pngse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .pix_valid  (req_tvalid),
      .pix_data   (req_tdata),
      .q_full     (q_full),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   pngse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   pngse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_run_end  (rsp_tlast),
      .out_file_end (rsp_tuser)
   );

   // the final file byte always closes its run
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("file end without run end");

   // the iend crc always ends in 0x82
   a_fend_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h82)
      else $error("bad closing byte");

   // the back end never retires a command the queue does not hold
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

// ===== tb/png_stored_stream_encoder_unit_checker.sv =====
// checker for the png encoder: tracks registers, predicts the file bytes and compares them
module png_stored_stream_encoder_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, alpha
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte
   input  logic        rsp_tlast,   // run_end
   input  logic        rsp_tuser,   // file_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [pngse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          bytes_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import pngse_pkg::*;

   localparam int TRAILER_LEN = 20;
   localparam int STEP_LIMIT  = 53;
   localparam logic [16:0] ADLER_BASE = 17'd65521;
   localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};

   typedef struct packed {
      logic [7:0] value;
      logic       run_end;
      logic       file_end;
   } file_byte_type;

   file_byte_type file_bytes[$];

   logic [DIM_W-1:0] width_reg, height_reg;
   logic [14:0]      run_width, run_height;
   logic [14:0]      col_pos;
   logic [14:0]      row_pos;
   logic [15:0]      fill;
   logic [30:0]      raw_left;
   logic [31:0]      crc;
   logic [15:0]      adler_a, adler_b;
   logic             in_file, closing_owed;

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic logic [14:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 15'd1;
      if (v > MAX_DIM) return 15'(MAX_DIM);
      return v;
   endfunction

   task automatic put_byte(logic [7:0] b, bit with_crc);
      file_bytes.insert(file_bytes.size(), '{b, 1'b0, 1'b0});
      if (with_crc) crc = crc_next(crc, b);
   endtask

   task automatic put_word(logic [31:0] w, bit with_crc);
      for (int s = 3; s >= 0; s--) put_byte(w[8*s +: 8], with_crc);
   endtask

   task automatic put_tag(logic [31:0] tag);
      crc = CRC_INIT;
      put_word(tag, 1);
   endtask

   task automatic put_raw(logic [7:0] b);
      logic [15:0] n;
      logic [16:0] sum;
      if (fill == 0) begin
         n = (raw_left < 31'(BLOCK_MAX)) ? raw_left[15:0] : BLOCK_MAX;
         put_byte({7'd0, 31'(n) == raw_left}, 1);
         put_byte(n[7:0], 1);
         put_byte(n[15:8], 1);
         put_byte(~n[7:0], 1);
         put_byte(~n[15:8], 1);
      end
      put_byte(b, 1);
      sum = adler_a + b;
      if (sum >= ADLER_BASE) sum -= ADLER_BASE;
      adler_a = sum[15:0];
      sum = adler_b + adler_a;
      if (sum >= ADLER_BASE) sum -= ADLER_BASE;
      adler_b = sum[15:0];
      fill++;
      if (raw_left > 0) raw_left--;
      if (fill >= BLOCK_MAX || raw_left == 0) fill = 0;
   endtask

   task automatic open_file();
      longint unsigned raw, blocks, idat_len;
      run_width  = clamp_dim(width_reg);
      run_height = clamp_dim(height_reg);
      raw      = (longint'(run_width) * 4 + 1) * longint'(run_height);
      blocks   = (raw + BLOCK_MAX - 1) / BLOCK_MAX;
      idat_len = 2 + 5 * blocks + raw + 4;
      foreach (PNG_MAGIC[i]) put_byte(PNG_MAGIC[i], 0);
      put_word(32'd13, 0);
      put_tag("IHDR");
      put_word({17'd0, run_width}, 1);
      put_word({17'd0, run_height}, 1);
      put_byte(8'd8, 1);
      put_byte(8'd6, 1);
      put_byte(8'd0, 1);
      put_byte(8'd0, 1);
      put_byte(8'd0, 1);
      put_word(~crc, 0);
      put_word(idat_len[31:0], 0);
      put_tag("IDAT");
      put_byte(8'h78, 1);
      put_byte(8'h01, 1);
      raw_left = raw[30:0];
      fill     = 0;
      adler_a  = 16'd1;
      adler_b  = 16'd0;
      col_pos  = 0;
      row_pos  = 0;
      in_file  = 1;
   endtask

   task automatic close_file();
      put_word({adler_b, adler_a}, 1);
      put_word(~crc, 0);
      put_word(32'd0, 0);
      put_tag("IEND");
      put_word(~crc, 0);
      file_bytes[file_bytes.size()-1].file_end = 1'b1;
      in_file      = 0;
      closing_owed = 0;
   endtask

   // all bytes one pixel beat gives rise to
   task automatic encode_pixel(logic [31:0] px);
      int base;
      base = file_bytes.size();
      if (closing_owed) begin
         close_file();
      end else begin
         if (!in_file) open_file();
         if (col_pos == 0) put_raw(8'h00);
         for (int k = 0; k < 4; k++) put_raw(px[8*k +: 8]);
         col_pos++;
         if (col_pos >= run_width) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= run_height) begin
               row_pos = 0;
               if (file_bytes.size() - base + TRAILER_LEN > STEP_LIMIT) closing_owed = 1;
               else close_file();
            end
         end
      end
      if (file_bytes.size() > base) file_bytes[file_bytes.size()-1].run_end = 1'b1;
   endtask

   always @(posedge clock) begin
      file_byte_type want;
      if (reset) begin
         file_bytes.delete();
         width_reg    <= 1;
         height_reg   <= 1;
         col_pos      = 0;
         row_pos      = 0;
         fill         = 0;
         raw_left     = 0;
         crc          = CRC_INIT;
         adler_a      = 16'd1;
         adler_b      = 16'd0;
         in_file      = 0;
         closing_owed = 0;
         fail_count   <= 0;
         bytes_owed   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_SEL_HEIGHT) height_reg <= csr_pwdata[DIM_W-1:0];
            else width_reg <= csr_pwdata[DIM_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (file_bytes.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected byte %02h last %b file_end %b", rsp_tdata, rsp_tlast,
                           rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = file_bytes.pop_front();
               if (want != {rsp_tdata, rsp_tlast, rsp_tuser}) begin
                  if (fail_count < 10)
                     $display("byte mismatch: expected %02h/%b/%b got %02h/%b/%b",
                              want.value, want.run_end, want.file_end,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // pixel pushed after the pop so a same-edge byte is never matched against it
         if (req_tvalid && req_tready) encode_pixel(req_tdata);
         bytes_owed <= file_bytes.size();
      end
   end
endmodule

// ===== tb/png_stored_stream_encoder_unit_tb.sv =====
// top of the png encoder testbench: clock, reset, pixel and register stimulus, verdict
module png_stored_stream_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pngse_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEIGHT = CSR_ADDR_W'(4);
   localparam int CYCLE_LIMIT = 200_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // red, green, blue, alpha
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;        // out_byte
   logic        rsp_tlast;        // run_end
   logic        rsp_tuser;        // file_end
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, bytes_owed;
   int cycles = 0;
   bit calm = 0;          // no idling on either side while set
   int hold_request = 0;  // receiver hold-off length asked for by the stimulus

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   png_stored_stream_encoder_unit dut (.*);

   png_stored_stream_encoder_unit_checker checker_i (.*);

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // byte sink: random stalls, mostly short, a few long, plus the requested hold-off
   always @(posedge clock) begin
      int stall_left, r;
      if (reset) begin
         rsp_tready <= 0;
         stall_left = 0;
      end else if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else if (calm) begin
         rsp_tready <= 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) rsp_tready <= 1;
         else begin
            rsp_tready <= 0;
            stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 40);
         end
      end
   end

   // one pixel beat; valid stays high across back-to-back beats
   task automatic send_pixel(logic [31:0] px);
      int gap, r;
      req_tvalid <= 1;
      req_tdata  <= px;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      r = $urandom_range(0, 99);
      gap = (calm || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pause until every byte owed has come out, then let the block settle
   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (bytes_owed != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic set_size(logic [31:0] w, logic [31:0] h);
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
   endtask

   // one whole image of random pixels; a one-pixel image needs an extra beat for its closing bytes
   task automatic random_image(int pixels);
      repeat (pixels) send_pixel($urandom);
      if (pixels == 1) send_pixel($urandom);
   endtask

   initial begin
      int w, h, sent;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset size 1x1: closing bytes ride on a second, ignored pixel
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      drain();

      // small image with extreme samples, no idling
      calm = 1;
      set_size(3, 2);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_00FF);
      send_pixel(32'h0000_FF00);
      send_pixel(32'h00FF_0000);
      send_pixel(32'hFF00_0000);
      drain();
      calm = 0;

      // zero sizes saturate to one
      set_size(0, 0);
      random_image(1);
      drain();

      // random small images; each file drains before the size changes
      sent = 0;
      while (sent < 100) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 5);
         set_size(w, h);
         random_image(w * h);
         sent += w * h;
         drain();
      end

      // long sink hold-off while pixels keep coming, so the queue fills
      set_size(8, 4);
      hold_request = 300;
      random_image(32);
      drain();

      // oversize sizes saturate to the maximum; a few pixels cover the headers,
      // the file stays open to the end of the run
      set_size(32'h7FFF, 32'hFFFF_FFFF);
      repeat (12) send_pixel($urandom);
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0 && bytes_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== png_stored_stream_encoder_unit.f =====
rtl/pngse_pkg.sv
rtl/pngse_front.sv
rtl/pngse_queue.sv
rtl/pngse_back.sv
rtl/png_stored_stream_encoder_unit.sv
tb/png_stored_stream_encoder_unit_checker.sv
tb/png_stored_stream_encoder_unit_tb.sv
